// ===== hdl/kf2_pkg.sv =====
package kf2_pkg;

    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int QWidth    = DataWidth - 1;
    localparam int IdxWidth  = 3;

    typedef logic signed [DataWidth-1:0] word_t;

    localparam word_t WordMax = {1'b0, {(DataWidth-1){1'b1}}};
    localparam word_t WordMin = {1'b1, {(DataWidth-1){1'b0}}};
    localparam word_t FixOne  = word_t'(64'sd1 <<< FracBits);

    // register indexes
    localparam logic [IdxWidth-1:0] RegPosFromVel  = 3'd0;
    localparam logic [IdxWidth-1:0] RegVelFromPos  = 3'd1;
    localparam logic [IdxWidth-1:0] RegVelFromVel  = 3'd2;
    localparam logic [IdxWidth-1:0] RegForceGain   = 3'd3;
    localparam logic [IdxWidth-1:0] RegQPosition   = 3'd4;
    localparam logic [IdxWidth-1:0] RegQVelocity   = 3'd5;
    localparam logic [IdxWidth-1:0] RegMeasNoise   = 3'd6;
    localparam logic [IdxWidth-1:0] RegInitPos     = 3'd7;

    // datapath operations
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // operand / result slots in the register file
    typedef enum logic [4:0] {
        R_ZERO = 5'd0,  R_A   = 5'd1,  R_B   = 5'd2,  R_C   = 5'd3,
        R_G    = 5'd4,  R_QP  = 5'd5,  R_QV  = 5'd6,  R_R   = 5'd7,
        R_POS  = 5'd8,  R_VEL = 5'd9,  R_P0  = 5'd10, R_P1  = 5'd11,
        R_P2   = 5'd12, R_P3  = 5'd13, R_U   = 5'd14, R_Z   = 5'd15,
        R_ONE  = 5'd16, R_X0  = 5'd17, R_X1  = 5'd18, R_T0  = 5'd19,
        R_T1   = 5'd20, R_T2  = 5'd21, R_T3  = 5'd22, R_N0  = 5'd23,
        R_N1   = 5'd24, R_N2  = 5'd25, R_N3  = 5'd26, R_S   = 5'd27,
        R_K0   = 5'd28, R_K1  = 5'd29, R_Y   = 5'd30, R_TMP = 5'd31
    } slot_t;

    typedef struct packed {
        logic  start;
        op_t   op;
        slot_t src_a;
        slot_t src_b;
        slot_t dst;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_stat_t;

    localparam int ProgLen = 44;
    localparam int PcWidth = 6;

    typedef struct packed {
        op_t   op;
        slot_t a;
        slot_t b;
        slot_t d;
    } instr_t;

    // microprogram, one entry per arithmetic step, in model order
    function automatic instr_t prog(input logic [PcWidth-1:0] pc);
        instr_t i;
        case (pc)
            6'd0:  i = '{OP_MUL, R_A,   R_VEL, R_TMP};
            6'd1:  i = '{OP_ADD, R_POS, R_TMP, R_X0};
            6'd2:  i = '{OP_MUL, R_B,   R_POS, R_X1};
            6'd3:  i = '{OP_MUL, R_C,   R_VEL, R_TMP};
            6'd4:  i = '{OP_ADD, R_X1,  R_TMP, R_X1};
            6'd5:  i = '{OP_MUL, R_G,   R_U,   R_TMP};
            6'd6:  i = '{OP_ADD, R_X1,  R_TMP, R_X1};
            6'd7:  i = '{OP_MUL, R_P1,  R_A,   R_TMP};
            6'd8:  i = '{OP_ADD, R_P0,  R_TMP, R_T0};
            6'd9:  i = '{OP_MUL, R_P3,  R_A,   R_TMP};
            6'd10: i = '{OP_ADD, R_P2,  R_TMP, R_T1};
            6'd11: i = '{OP_MUL, R_P0,  R_B,   R_T2};
            6'd12: i = '{OP_MUL, R_P1,  R_C,   R_TMP};
            6'd13: i = '{OP_ADD, R_T2,  R_TMP, R_T2};
            6'd14: i = '{OP_MUL, R_P2,  R_B,   R_T3};
            6'd15: i = '{OP_MUL, R_P3,  R_C,   R_TMP};
            6'd16: i = '{OP_ADD, R_T3,  R_TMP, R_T3};
            6'd17: i = '{OP_MUL, R_A,   R_T1,  R_TMP};
            6'd18: i = '{OP_ADD, R_T0,  R_TMP, R_N0};
            6'd19: i = '{OP_ADD, R_N0,  R_QP,  R_N0};
            6'd20: i = '{OP_MUL, R_A,   R_T3,  R_TMP};
            6'd21: i = '{OP_ADD, R_T2,  R_TMP, R_N1};
            6'd22: i = '{OP_MUL, R_B,   R_T0,  R_N2};
            6'd23: i = '{OP_MUL, R_C,   R_T1,  R_TMP};
            6'd24: i = '{OP_ADD, R_N2,  R_TMP, R_N2};
            6'd25: i = '{OP_MUL, R_B,   R_T2,  R_N3};
            6'd26: i = '{OP_MUL, R_C,   R_T3,  R_TMP};
            6'd27: i = '{OP_ADD, R_N3,  R_TMP, R_N3};
            6'd28: i = '{OP_ADD, R_N3,  R_QV,  R_N3};
            6'd29: i = '{OP_ADD, R_N0,  R_R,   R_S};
            6'd30: i = '{OP_DIV, R_N0,  R_S,   R_K0};
            6'd31: i = '{OP_DIV, R_N2,  R_S,   R_K1};
            6'd32: i = '{OP_SUB, R_Z,   R_X0,  R_Y};
            6'd33: i = '{OP_MUL, R_K0,  R_Y,   R_TMP};
            6'd34: i = '{OP_ADD, R_X0,  R_TMP, R_POS};
            6'd35: i = '{OP_MUL, R_K1,  R_Y,   R_TMP};
            6'd36: i = '{OP_ADD, R_X1,  R_TMP, R_VEL};
            6'd37: i = '{OP_SUB, R_ONE, R_K0,  R_Y};
            6'd38: i = '{OP_MUL, R_Y,   R_N0,  R_P0};
            6'd39: i = '{OP_MUL, R_Y,   R_N1,  R_P1};
            6'd40: i = '{OP_MUL, R_K1,  R_N0,  R_TMP};
            6'd41: i = '{OP_SUB, R_N2,  R_TMP, R_P2};
            6'd42: i = '{OP_MUL, R_K1,  R_N1,  R_TMP};
            6'd43: i = '{OP_SUB, R_N3,  R_TMP, R_P3};
            default: i = '{OP_ADD, R_ZERO, R_ZERO, R_TMP};
        endcase
        return i;
    endfunction

    function automatic word_t sat_wide(input logic signed [DataWidth+1:0] v);
        word_t r;
        if (v > (DataWidth+2)'(WordMax))
            r = WordMax;
        else if (v < (DataWidth+2)'(WordMin))
            r = WordMin;
        else
            r = v[DataWidth-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/kf2_datapath.sv =====
module kf2_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kf2_pkg::dp_cmd_t                cmd,
    output kf2_pkg::dp_stat_t               stat,
    input  logic                            reinit,
    input  logic                            cfg_we,
    input  logic [kf2_pkg::IdxWidth-1:0]    cfg_idx,
    input  logic [kf2_pkg::DataWidth-1:0]   cfg_val,
    input  logic                            load_in,
    input  logic [kf2_pkg::DataWidth-1:0]   in_u,
    input  logic [kf2_pkg::DataWidth-1:0]   in_z,
    output logic [kf2_pkg::DataWidth-1:0]   pos,
    output logic [kf2_pkg::DataWidth-1:0]   vel
);
    import kf2_pkg::*;

    localparam int PW = 2 * DataWidth;
    localparam int DivW = DataWidth + FracBits + 1;
    localparam int CntW = $clog2(DivW + 1);

    word_t rf_reg [32];
    word_t rf_next_val;
    logic  rf_we;
    slot_t dst_reg;
    op_t   op_reg;
    word_t oa_reg, ob_reg;
    word_t init_pos_reg;
    logic  mul_ph_reg;
    logic signed [PW-1:0] prod_reg;

    // divider state
    logic            div_run_reg;
    logic [CntW-1:0] div_cnt_reg;
    logic [DivW-1:0] quo_reg, rem_reg, den_reg;
    logic [DivW-1:0] num_reg;
    logic            neg_reg, zero_reg;
    logic            busy_reg;

    word_t ra, rb;
    logic signed [DataWidth+1:0] sum_w;
    logic signed [PW-1:0] shf;
    logic [DivW-1:0] rem_sh;
    logic [DivW:0]   quo_w;

    assign ra = rf_reg[cmd.src_a];
    assign rb = rf_reg[cmd.src_b];

    // combinational result paths
    always_comb
    begin
        rf_we = 1'b0;
        rf_next_val = '0;
        stat.busy = busy_reg;
        stat.done = 1'b0;
        sum_w = '0;
        shf = prod_reg >>> FracBits;
        rem_sh = {rem_reg[DivW-2:0], num_reg[DivW-1]};
        quo_w = '0;
        if (busy_reg)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    sum_w = (DataWidth+2)'(oa_reg) + (DataWidth+2)'(ob_reg);
                    rf_next_val = sat_wide(sum_w);
                    rf_we = 1'b1;
                end
                OP_SUB:
                begin
                    sum_w = (DataWidth+2)'(oa_reg) - (DataWidth+2)'(ob_reg);
                    rf_next_val = sat_wide(sum_w);
                    rf_we = 1'b1;
                end
                OP_MUL:
                begin
                    if (mul_ph_reg)
                    begin
                        if (shf > PW'(WordMax))
                            rf_next_val = WordMax;
                        else if (shf < PW'(WordMin))
                            rf_next_val = WordMin;
                        else
                            rf_next_val = shf[DataWidth-1:0];
                        rf_we = 1'b1;
                    end
                end
                OP_DIV:
                begin
                    if (div_run_reg && div_cnt_reg == '0)
                    begin
                        quo_w = {1'b0, quo_reg};
                        if (zero_reg)
                            rf_next_val = '0;
                        else if (neg_reg)
                        begin
                            if (quo_w > (DivW+1)'(WordMax) + 1)
                                rf_next_val = WordMin;
                            else
                                rf_next_val = word_t'(-quo_w);
                        end
                        else if (quo_w > (DivW+1)'(WordMax))
                            rf_next_val = WordMax;
                        else
                            rf_next_val = quo_reg[DataWidth-1:0];
                        rf_we = 1'b1;
                    end
                end
                default: rf_we = 1'b0;
            endcase
        end
        stat.done = rf_we;
    end

    // register file, operand capture, multiplier and divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_ph_reg <= 1'b0;
            div_run_reg <= 1'b0;
            div_cnt_reg <= '0;
            init_pos_reg <= '0;
            for (int k = 0; k < 32; k++)
                rf_reg[k] <= (k == int'(R_R) || k == int'(R_ONE) ||
                              k == int'(R_P0) || k == int'(R_P3)) ? FixOne : '0;
        end
        else
        begin
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg <= cmd.op;
                dst_reg <= cmd.dst;
                oa_reg <= ra;
                ob_reg <= rb;
                mul_ph_reg <= 1'b0;
                div_run_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (op_reg == OP_MUL && !mul_ph_reg)
                begin
                    prod_reg <= PW'(oa_reg) * PW'(ob_reg);
                    mul_ph_reg <= 1'b1;
                end
                if (op_reg == OP_DIV)
                begin
                    if (!div_run_reg)
                    begin
                        div_run_reg <= 1'b1;
                        div_cnt_reg <= CntW'(DivW);
                        zero_reg <= (ob_reg <= 0);
                        neg_reg <= oa_reg[DataWidth-1];
                        num_reg <= (oa_reg[DataWidth-1]
                            ? DivW'(-(DivW'(oa_reg))) : DivW'(oa_reg)) << FracBits;
                        den_reg <= DivW'(ob_reg);
                        rem_reg <= '0;
                        quo_reg <= '0;
                    end
                    else if (div_cnt_reg != '0)
                    begin
                        div_cnt_reg <= div_cnt_reg - 1'b1;
                        num_reg <= num_reg << 1;
                        if (rem_sh >= den_reg)
                        begin
                            rem_reg <= rem_sh - den_reg;
                            quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                        end
                    end
                end
                if (rf_we)
                begin
                    busy_reg <= 1'b0;
                    rf_reg[dst_reg] <= rf_next_val;
                end
            end
            // load input words
            if (load_in)
            begin
                rf_reg[R_U] <= in_u;
                rf_reg[R_Z] <= in_z;
            end
            // configuration and reinitialisation
            if (cfg_we)
            begin
                case (cfg_idx)
                    RegPosFromVel: rf_reg[R_A]  <= cfg_val;
                    RegVelFromPos: rf_reg[R_B]  <= cfg_val;
                    RegVelFromVel: rf_reg[R_C]  <= cfg_val;
                    RegForceGain:  rf_reg[R_G]  <= cfg_val;
                    RegQPosition:  rf_reg[R_QP] <= {1'b0, cfg_val[QWidth-1:0]};
                    RegQVelocity:  rf_reg[R_QV] <= {1'b0, cfg_val[QWidth-1:0]};
                    RegMeasNoise:  rf_reg[R_R]  <= {1'b0, cfg_val[QWidth-1:0]};
                    RegInitPos:    init_pos_reg <= cfg_val;
                    default:       rf_reg[R_ZERO] <= '0;
                endcase
            end
            if (reinit)
            begin
                rf_reg[R_P0] <= FixOne;
                rf_reg[R_P1] <= '0;
                rf_reg[R_P2] <= '0;
                rf_reg[R_P3] <= FixOne;
                rf_reg[R_VEL] <= '0;
                rf_reg[R_POS] <= init_pos_reg;
            end
        end
    end

    assign pos = rf_reg[R_POS];
    assign vel = rf_reg[R_VEL];

endmodule

// ===== hdl/kf2_ctrl.sv =====
module kf2_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    output logic               load_in,
    output logic               out_load,
    input  logic               out_free,
    output kf2_pkg::dp_cmd_t   cmd,
    input  kf2_pkg::dp_stat_t  stat
);
    import kf2_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [PcWidth-1:0] pc_reg, pc_next;
    instr_t ins;

    assign ins = prog(pc_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign load_in = in_fire;

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        cmd = '{start: 1'b0, op: ins.op, src_a: ins.a, src_b: ins.b, dst: ins.d};
        out_load = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    state_next = S_ISSUE;
                    pc_next = '0;
                end
            S_ISSUE:
            begin
                cmd.start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
                if (stat.done)
                begin
                    if (pc_reg == PcWidth'(ProgLen - 1))
                        state_next = S_OUT;
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            S_OUT:
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/kalman_filter_two_state.sv =====
// Two-state (position, velocity) Kalman filter, signed Q16.16.
// Channels:
//   s_axis: one word per measurement, tdata = {measured_pos, ext_force}.
//   m_axis: one word per input, tdata = {est_velocity, est_position}.
//   cfg:    register writes (cfg_index 0..15, cfg_data). Any write to index
//           0..7 reloads P = identity, position = init_position, velocity
//           = 0 in the next cycle. cfg_ready is high only while the filter
//           is idle, and a pending write holds off s_axis.
// Schedule: 44 micro-steps run one at a time on one shared datapath. The
//   filter works on one measurement at a time: the next word is taken once
//   the result sits in the output register. The restoring divider for the
//   two gains takes the largest share of the time spent on each item.
// Reset: rst_n clears the state to zero position and velocity, P =
//   identity, R = 1.0, the constant-one slot = 1.0, all other registers zero.
// Stall: a held m_axis word keeps its value; the filter finishes its next
//   item and waits for the output register to drain.
module kalman_filter_two_state (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] ext_force, [63:32] measured_pos
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] est_position, [63:32] est_velocity
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [kf2_pkg::IdxWidth:0]    cfg_index,
    input  logic [kf2_pkg::DataWidth-1:0] cfg_data
);
    import kf2_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic in_fire, in_ready, load_in, out_load, out_free;
    logic cfg_fire, cfg_hit, reinit_reg;
    word_t pos, vel;
    logic [63:0] out_reg;
    logic out_valid_reg;

    // configuration takes priority over a new measurement word
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = in_ready && !cfg_valid;
    assign cfg_ready = in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign cfg_hit = cfg_fire && !cfg_index[IdxWidth];
    assign out_free = !out_valid_reg || m_axis_tready;

    kf2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (in_ready),
        .load_in  (load_in),
        .out_load (out_load),
        .out_free (out_free),
        .cmd      (cmd),
        .stat     (stat)
    );

    kf2_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .reinit  (reinit_reg),
        .cfg_we  (cfg_hit),
        .cfg_idx (cfg_index[IdxWidth-1:0]),
        .cfg_val (cfg_data),
        .load_in (load_in),
        .in_u    (s_axis_tdata[31:0]),
        .in_z    (s_axis_tdata[63:32]),
        .pos     (pos),
        .vel     (vel)
    );

    // reload the state in the cycle after a listed register is written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reinit_reg <= 1'b0;
        else
            reinit_reg <= cfg_hit;
    end

    // hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= {vel, pos};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

endmodule

// ===== hdl/kf2_checker.sv =====
module kf2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    // a held result word keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one item at a time: no input taken right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a result never appears in the cycle after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind kalman_filter_two_state kf2_checker u_kf2_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
